// File: rtl/core/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared constants and types for the lidar frame parser with offline timer.
// ----------------------------------------------------------------------------
package lfp_pkg;

  // frame layout
  localparam int unsigned FRAME_LENGTH = 9;
  localparam int unsigned PAYLOAD_LEN  = FRAME_LENGTH - 3;
  localparam int unsigned POS_W        = 4;

  localparam logic [7:0]       HEADER_BYTE = 8'h59;
  localparam logic [POS_W-1:0] POS_HDR0    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_DATA0   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CHECK   = POS_W'(FRAME_LENGTH - 1);

  // offline timer
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned ELAPSED_W   = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

  // input item kinds
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef logic signed [15:0] meas_t;

  // one step handed from the input register to the workers
  typedef struct packed {
    logic       fire;
    logic       action;
    logic [7:0] rx_byte;
    logic [7:0] tick_ms;
  } step_t;

  // hunter outcome for the current step (values after the step)
  typedef struct packed {
    logic  frame_done;
    meas_t distance;
    meas_t strength;
    meas_t temperature;
  } frame_t;

endpackage

// File: rtl/core/lfp_in_if.sv
// ----------------------------------------------------------------------------
// lfp_in_if
// Input channel: received byte or millisecond tick, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic [7:0] tick_ms;

  modport source (output valid, action, rx_byte, tick_ms, input ready);
  modport sink   (input valid, action, rx_byte, tick_ms, output ready);
endinterface

// File: rtl/core/lfp_out_if.sv
// ----------------------------------------------------------------------------
// lfp_out_if
// Result channel: frame status, latched measurements and offline flag.
// ----------------------------------------------------------------------------
interface lfp_out_if;
  logic               valid;
  logic               ready;
  logic               frame_done;
  logic signed [15:0] distance;
  logic signed [15:0] strength;
  logic signed [15:0] temperature;
  logic               offline;

  modport source (output valid, frame_done, distance, strength, temperature, offline,
                  input ready);
  modport sink   (input valid, frame_done, distance, strength, temperature, offline,
                  output ready);
endinterface

// File: rtl/core/lidar_frame_parser_with_timeout_core.sv
// ----------------------------------------------------------------------------
// lidar_frame_parser_with_timeout_core
// Path: input register, then result register, which drives out valid.
// Throughput: one item per cycle unless out ready stalls the result register;
//   the frame hunter and timer update in one pass.
// Reset: asynchronous, active low; limit returns to 1000 ms, measurements and
//   offline flag clear, hunter restarts at the first header byte.
// ----------------------------------------------------------------------------
module lidar_frame_parser_with_timeout_core import lfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  lfp_in_if.sink             in_i,
  lfp_out_if.source          out_o
);

  logic       s1_valid_q;
  logic       s1_action_q;
  logic [7:0] s1_byte_q;
  logic [7:0] s1_tick_q;
  logic       out_valid_q;
  frame_t     res_q;
  logic       res_offline_q;
  logic       advance;
  logic       in_xfer;
  step_t      step;
  frame_t     frame;
  logic       offline;

  // handshake: stage 1 moves on when the result register is free or drained
  assign advance   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_xfer   = in_i.valid && in_i.ready;

  assign step.fire    = s1_valid_q && advance;
  assign step.action  = s1_action_q;
  assign step.rx_byte = s1_byte_q;
  assign step.tick_ms = s1_tick_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (step.fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_action_q <= in_i.action;
      s1_byte_q   <= in_i.rx_byte;
      s1_tick_q   <= in_i.tick_ms;
    end
  end

  lfp_hunter u_hunter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .frame_o (frame)
  );

  lfp_timer u_timer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .step_i       (step),
    .frame_good_i (frame.frame_done),
    .offline_o    (offline)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step.fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.fire) begin
      res_q         <= frame;
      res_offline_q <= offline;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.frame_done  = res_q.frame_done;
  assign out_o.distance    = res_q.distance;
  assign out_o.strength    = res_q.strength;
  assign out_o.temperature = res_q.temperature;
  assign out_o.offline     = res_offline_q;

endmodule

// File: rtl/core/lfp_hunter.sv
// ----------------------------------------------------------------------------
// lfp_hunter
// Frame hunter: header match, payload capture, running checksum and
// measurement latches. Gives the post-step measurements to the result stage.
// ----------------------------------------------------------------------------
module lfp_hunter import lfp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  step_t  step_i,
  output frame_t frame_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       payload_q [PAYLOAD_LEN];
  meas_t            dist_q, dist_d;
  meas_t            str_q, str_d;
  meas_t            temp_q, temp_d;
  logic             byte_en;
  logic             good;
  logic [7:0]       sum_add;

  assign byte_en = step_i.fire && (step_i.action == ACT_BYTE);
  assign sum_add = sum_q + step_i.rx_byte;

  // frame position, checksum and measurement latch update
  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    good   = 1'b0;
    dist_d = dist_q;
    str_d  = str_q;
    temp_d = temp_q;
    if (byte_en) begin
      if (pos_q == POS_HDR0) begin
        sum_d = step_i.rx_byte;
        pos_d = (step_i.rx_byte == HEADER_BYTE) ? POS_HDR1 : POS_HDR0;
      end else if (pos_q == POS_HDR1) begin
        sum_d = sum_add;
        pos_d = (step_i.rx_byte == HEADER_BYTE) ? POS_DATA0 : POS_HDR0;
      end else if (pos_q >= POS_CHECK) begin
        if (sum_q == step_i.rx_byte) begin
          good   = 1'b1;
          dist_d = {payload_q[1], payload_q[0]};
          str_d  = {payload_q[3], payload_q[2]};
          temp_d = {payload_q[5], payload_q[4]};
        end
        pos_d = POS_HDR0;
      end else begin
        sum_d = sum_add;
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  // control state and latched measurements
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_HDR0;
      sum_q  <= '0;
      dist_q <= '0;
      str_q  <= '0;
      temp_q <= '0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      dist_q <= dist_d;
      str_q  <= str_d;
      temp_q <= temp_d;
    end
  end

  // payload capture, one byte slot per data position
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      if (byte_en && (pos_q == POS_DATA0 + POS_W'(k))) begin
        payload_q[k] <= step_i.rx_byte;
      end
    end
  end

  assign frame_o.frame_done  = good;
  assign frame_o.distance    = dist_d;
  assign frame_o.strength    = str_d;
  assign frame_o.temperature = temp_d;

endmodule

// File: rtl/core/lfp_timer.sv
// ----------------------------------------------------------------------------
// lfp_timer
// Offline timer: accumulates tick time while below the limit, flags offline on
// the next tick, cleared by a good frame. Holds the limit register.
// ----------------------------------------------------------------------------
module lfp_timer import lfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  input  step_t              step_i,
  input  logic               frame_good_i,
  output logic               offline_o
);

  logic [LIMIT_W-1:0]   limit_q;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic                 offline_q, offline_d;
  logic                 below;

  assign below = elapsed_q < ELAPSED_W'(limit_q);

  // elapsed time and offline flag
  always_comb begin
    elapsed_d = elapsed_q;
    offline_d = offline_q;
    if (frame_good_i) begin
      elapsed_d = '0;
      offline_d = 1'b0;
    end else if (step_i.fire && (step_i.action == ACT_TICK)) begin
      if (below) begin
        elapsed_d = elapsed_q + ELAPSED_W'(step_i.tick_ms);
      end else begin
        offline_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_RESET;
      elapsed_q <= '0;
      offline_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      elapsed_q <= elapsed_d;
      offline_q <= offline_d;
    end
  end

  assign offline_o = offline_d;

endmodule
